// ----- design/ct5_pkg.sv -----
package ct5_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int FILL_W    = $clog2(MAX_WIDTH + 1);
    localparam int LW_W      = 12;
    localparam int PIX_W     = 8;
    localparam int WIN       = 5;
    localparam int CENTRE    = WIN / 2;
    localparam int CENSUS_W  = WIN * WIN - 1;
    localparam int STORES    = WIN - 1;
    localparam int LINE_W    = STORES * PIX_W;

    localparam logic [LW_W-1:0]  LINE_WIDTH_RESET = LW_W'(1280);
    localparam logic [LW_W-1:0]  BORDER_LW        = LW_W'(2);
    localparam logic [COL_W-1:0] BORDER_COL       = COL_W'(2);
    localparam logic [COL_W-1:0] COL_MAX          = COL_W'(MAX_WIDTH - 1);
    localparam logic [1:0]       ROW_BORDER       = 2'd2;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [LINE_W-1:0] line_t;

    // Side-band fields that travel with the pixel unchanged.
    typedef struct packed {
        logic       frame_start;
        logic       line_end;
        logic [2:0] byte_keep;
        logic [2:0] byte_strobe;
        logic       stream_id;
        logic       stream_dest;
    } side_t;

endpackage

// ----- design/ct5_pixel_if.sv -----
interface ct5_pixel_if;
    logic                     valid;
    logic                     ready;
    logic [ct5_pkg::PIX_W-1:0] pixel;
    logic                     frame_start;
    logic                     line_end;
    logic [2:0]               byte_keep;
    logic [2:0]               byte_strobe;
    logic                     stream_id;
    logic                     stream_dest;

    modport source (
        output valid, pixel, frame_start, line_end, byte_keep, byte_strobe,
               stream_id, stream_dest,
        input  ready
    );
    modport sink (
        input  valid, pixel, frame_start, line_end, byte_keep, byte_strobe,
               stream_id, stream_dest,
        output ready
    );
endinterface

// ----- design/ct5_census_if.sv -----
interface ct5_census_if;
    logic                         valid;
    logic                         ready;
    logic [ct5_pkg::CENSUS_W-1:0] census_word;
    logic                         frame_start_out;
    logic                         line_end_out;
    logic [2:0]                   byte_keep_out;
    logic [2:0]                   byte_strobe_out;
    logic                         stream_id_out;
    logic                         stream_dest_out;

    modport source (
        output valid, census_word, frame_start_out, line_end_out, byte_keep_out,
               byte_strobe_out, stream_id_out, stream_dest_out,
        input  ready
    );
    modport sink (
        input  valid, census_word, frame_start_out, line_end_out, byte_keep_out,
               byte_strobe_out, stream_id_out, stream_dest_out,
        output ready
    );
endinterface

// ----- design/ct5_ram.sv -----
module ct5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/census_transform_5x5_top.sv -----
// 5x5 census transform over a raster stream of 8-bit pixels. One pixel word is
// taken every clock unless back-pressured; the rate is set by the single
// line-store RAM, which is read once at accept and written once as the pixel
// leaves stage 1, with a forwarding register for back-to-back hits on the same
// column. The four line stores share one 2048 x 32 dual-port RAM. Columns
// are always written in order from zero, so a fill mark stands in for the
// reset clear: columns never written read as zero, and the block is ready
// right after reset with no clearing pass. The census word is zero within two
// columns of either edge (line_width sets the right edge) and on the first two
// rows after frame start. Write line_width only while the block is idle.
module census_transform_5x5_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [ct5_pkg::LW_W-1:0]  cfg_wr_data,
    ct5_pixel_if.sink                 pixel_stream,
    ct5_census_if.source              census_stream
);

    localparam int W = ct5_pkg::WIN;
    localparam int P = ct5_pkg::PIX_W;

    logic [ct5_pkg::LW_W-1:0]   line_width_reg;
    ct5_pkg::col_t              col_count_reg, col_count_next;
    logic [1:0]                 row_count_reg, row_count_next;
    logic [ct5_pkg::FILL_W-1:0] fill_reg;

    logic           accept, s1_adv, in_ready;
    ct5_pkg::col_t  col_now;
    logic [1:0]     row_now;
    logic           border_now;

    // Stage 1: pixel waiting for its line-store column.
    logic           s1_valid_reg;
    ct5_pkg::pix_t  s1_pix_reg;
    ct5_pkg::col_t  s1_col_reg;
    logic           s1_border_reg;
    ct5_pkg::side_t s1_side_reg;
    logic           fwd_hit_reg;
    ct5_pkg::line_t fwd_data_reg;
    logic           rd_zero_reg;

    ct5_pkg::line_t ram_rdata, line_col, wr_data;

    logic [P-1:0] win_reg  [W][W];
    logic [P-1:0] win_next [W][W];
    logic [ct5_pkg::CENSUS_W-1:0] census;

    logic                         out_valid_reg;
    logic [ct5_pkg::CENSUS_W-1:0] out_word_reg;
    ct5_pkg::side_t               out_side_reg;
    ct5_pkg::side_t               in_side;

    assign in_side = '{
        frame_start: pixel_stream.frame_start,
        line_end:    pixel_stream.line_end,
        byte_keep:   pixel_stream.byte_keep,
        byte_strobe: pixel_stream.byte_strobe,
        stream_id:   pixel_stream.stream_id,
        stream_dest: pixel_stream.stream_dest
    };

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || census_stream.ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = pixel_stream.valid && in_ready;
    assign pixel_stream.ready = in_ready;

    // Frame start restarts the counters before the pixel is placed.
    assign col_now = pixel_stream.frame_start ? '0 : col_count_reg;
    assign row_now = pixel_stream.frame_start ? 2'd0 : row_count_reg;

    // With line_width of two or less the right test alone covers every column.
    assign border_now = (col_now < ct5_pkg::BORDER_COL)
                     || (({1'b0, col_now} + ct5_pkg::BORDER_LW) >= line_width_reg)
                     || (row_now < ct5_pkg::ROW_BORDER);

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (pixel_stream.line_end)
            begin
                col_count_next = '0;
                row_count_next = (row_now < ct5_pkg::ROW_BORDER) ? row_now + 2'd1 : row_now;
            end
            else
            begin
                row_count_next = row_now;
                col_count_next = (col_now == ct5_pkg::COL_MAX) ? col_now : col_now + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= ct5_pkg::LINE_WIDTH_RESET;
            col_count_reg  <= '0;
            row_count_reg  <= 2'd0;
            fill_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                line_width_reg <= cfg_wr_data;
            end
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            // Writes never skip past the fill mark, so it only ever steps by one.
            if (s1_adv && ({1'b0, s1_col_reg} == fill_reg))
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (census_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The RAM read issued at accept sees old data when the pixel ahead writes
    // the same column on that edge, so that write is caught here.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg    <= pixel_stream.pixel;
            s1_col_reg    <= col_now;
            s1_border_reg <= border_now;
            s1_side_reg   <= in_side;
            fwd_hit_reg   <= s1_adv && (s1_col_reg == col_now);
            fwd_data_reg  <= wr_data;
            rd_zero_reg   <= {1'b0, col_now} >= fill_reg;
        end
        if (s1_adv)
        begin
            out_word_reg <= s1_border_reg ? '0 : census;
            out_side_reg <= s1_side_reg;
        end
    end

    ct5_ram #(
        .WIDTH (ct5_pkg::LINE_W),
        .DEPTH (ct5_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (col_now),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            line_col = fwd_data_reg;
        end
        else if (rd_zero_reg)
        begin
            line_col = '0;
        end
        else
        begin
            line_col = ram_rdata;
        end
    end

    // Rows move up one store: oldest in the low byte, newest in the high byte.
    assign wr_data = {s1_pix_reg, line_col[ct5_pkg::LINE_W-1:P]};

    always_comb
    begin
        for (int r = 0; r < W; r++)
        begin
            for (int c = 0; c < W - 1; c++)
            begin
                win_next[r][c] = s1_side_reg.frame_start ? '0 : win_reg[r][c+1];
            end
        end
        for (int r = 0; r < W - 1; r++)
        begin
            win_next[r][W-1] = line_col[r*P +: P];
        end
        win_next[W-1][W-1] = s1_pix_reg;
    end

    always_comb
    begin
        int pos;
        pos    = 0;
        census = '0;
        for (int r = 0; r < W; r++)
        begin
            for (int c = 0; c < W; c++)
            begin
                if (!(r == ct5_pkg::CENTRE && c == ct5_pkg::CENTRE))
                begin
                    census[pos] = win_next[r][c] >=
                                  win_next[ct5_pkg::CENTRE][ct5_pkg::CENTRE];
                    pos++;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < W; r++)
            begin
                for (int c = 0; c < W; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (s1_adv)
        begin
            win_reg <= win_next;
        end
    end

    assign census_stream.valid           = out_valid_reg;
    assign census_stream.census_word     = out_word_reg;
    assign census_stream.frame_start_out = out_side_reg.frame_start;
    assign census_stream.line_end_out    = out_side_reg.line_end;
    assign census_stream.byte_keep_out   = out_side_reg.byte_keep;
    assign census_stream.byte_strobe_out = out_side_reg.byte_strobe;
    assign census_stream.stream_id_out   = out_side_reg.stream_id;
    assign census_stream.stream_dest_out = out_side_reg.stream_dest;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= ct5_pkg::FILL_W'(ct5_pkg::MAX_WIDTH))
        else $error("line store fill mark beyond store depth");

    a_write_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |-> ({1'b0, s1_col_reg} <= fill_reg))
        else $error("line store write skips past the fill mark");

    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_border_reg) |=> (census_stream.census_word == '0))
        else $error("census word not zero at border");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid_reg && !census_stream.ready && s1_valid_reg))
        else $error("input held off without an output stall");
`endif

endmodule

// ----- test/census_transform_5x5_top_tb.sv -----
`timescale 1ns / 1ps

module census_transform_5x5_top_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_AT    = 150;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int DIR_ROWS       = 24;
    localparam int PHASES         = 12;

    typedef struct packed {
        ct5_pkg::pix_t  pixel;
        ct5_pkg::side_t side;
    } pixel_word_t;

    typedef struct packed {
        logic [ct5_pkg::CENSUS_W-1:0] word;
        ct5_pkg::side_t               side;
    } census_res_t;

    // One directed stimulus row; known marks rows whose census word is typed in.
    typedef struct packed {
        logic [7:0]                   pix;
        logic                         sof;
        logic                         eol;
        logic [2:0]                   keep;
        logic [2:0]                   strobe;
        logic                         id;
        logic                         dest;
        logic                         known;
        logic [ct5_pkg::CENSUS_W-1:0] word;
    } dir_row_t;

    typedef struct packed {
        logic [ct5_pkg::LW_W-1:0] lw;
        logic [15:0]              len;
        logic [15:0]              items;
        logic                     noisy;
    } phase_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [ct5_pkg::LW_W-1:0] cfg_wr_data;

    ct5_pixel_if  pixel_bus ();
    ct5_census_if census_bus ();

    census_transform_5x5_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .pixel_stream  (pixel_bus),
        .census_stream (census_bus)
    );

    // Predictor state: store 0 holds the oldest row, store 3 the newest.
    ct5_pkg::pix_t            line_store [ct5_pkg::STORES][ct5_pkg::MAX_WIDTH];
    ct5_pkg::pix_t            win_q [ct5_pkg::WIN][ct5_pkg::WIN];
    int unsigned              col_cnt;
    int unsigned              row_cnt;
    logic [ct5_pkg::LW_W-1:0] lw_model;

    census_res_t census_expect [$];
    int          error_count;
    bit          src_idle;
    bit          pixel_offered;
    int          quiet_cycles;

    // Line width is reset value in the directed part; the first four rows are five pixels long.
    dir_row_t dir_table [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b0, 3'd0, 3'd7, 1'b0, 1'b1, 1'b1, 24'h0},
        '{8'hff, 1'b0, 1'b0, 3'd7, 3'd0, 1'b1, 1'b0, 1'b1, 24'h0},
        '{8'h00, 1'b0, 1'b0, 3'd0, 3'd0, 1'b0, 1'b0, 1'b1, 24'h0},
        '{8'hff, 1'b0, 1'b0, 3'd7, 3'd7, 1'b1, 1'b1, 1'b1, 24'h0},
        '{8'h80, 1'b0, 1'b1, 3'd5, 3'd2, 1'b0, 1'b1, 1'b1, 24'h0},
        '{8'h7f, 1'b0, 1'b0, 3'd2, 3'd5, 1'b1, 1'b0, 1'b1, 24'h0},
        '{8'h01, 1'b0, 1'b0, 3'd1, 3'd6, 1'b0, 1'b0, 1'b1, 24'h0},
        '{8'hfe, 1'b0, 1'b0, 3'd6, 3'd1, 1'b1, 1'b1, 1'b1, 24'h0},
        '{8'h80, 1'b0, 1'b0, 3'd3, 3'd4, 1'b0, 1'b1, 1'b1, 24'h0},
        '{8'h80, 1'b0, 1'b1, 3'd4, 3'd3, 1'b1, 1'b0, 1'b1, 24'h0},
        '{8'h40, 1'b0, 1'b0, 3'd7, 3'd7, 1'b0, 1'b0, 1'b1, 24'h0},
        '{8'hc0, 1'b0, 1'b0, 3'd0, 3'd0, 1'b1, 1'b1, 1'b1, 24'h0},
        '{8'h80, 1'b0, 1'b0, 3'd1, 3'd2, 1'b0, 1'b1, 1'b0, 24'h0},
        '{8'h00, 1'b0, 1'b0, 3'd2, 3'd1, 1'b1, 1'b0, 1'b0, 24'h0},
        '{8'hff, 1'b0, 1'b1, 3'd7, 3'd0, 1'b0, 1'b0, 1'b0, 24'h0},
        '{8'h80, 1'b0, 1'b0, 3'd0, 3'd7, 1'b1, 1'b1, 1'b1, 24'h0},
        '{8'h80, 1'b0, 1'b0, 3'd5, 3'd5, 1'b0, 1'b1, 1'b1, 24'h0},
        '{8'h80, 1'b0, 1'b0, 3'd6, 3'd6, 1'b1, 1'b0, 1'b0, 24'h0},
        '{8'h80, 1'b0, 1'b0, 3'd3, 3'd3, 1'b0, 1'b0, 1'b0, 24'h0},
        '{8'h80, 1'b0, 1'b1, 3'd4, 3'd4, 1'b1, 1'b1, 1'b0, 24'h0},
        '{8'h11, 1'b0, 1'b0, 3'd7, 3'd1, 1'b0, 1'b1, 1'b1, 24'h0},
        '{8'h22, 1'b0, 1'b0, 3'd1, 3'd7, 1'b1, 1'b0, 1'b1, 24'h0},
        '{8'h33, 1'b1, 1'b0, 3'd2, 3'd2, 1'b0, 1'b0, 1'b1, 24'h0},
        '{8'h44, 1'b1, 1'b1, 3'd5, 3'd6, 1'b1, 1'b1, 1'b1, 24'h0}
    };

    // The 4095 setting puts the right edge far beyond the store depth.
    phase_t phase_table [PHASES] = '{
        '{12'd5,    16'd5,  16'd30, 1'b0},
        '{12'd7,    16'd7,  16'd50, 1'b1},
        '{12'd2,    16'd6,  16'd30, 1'b0},
        '{12'd0,    16'd6,  16'd20, 1'b0},
        '{12'd1,    16'd5,  16'd20, 1'b0},
        '{12'd3,    16'd5,  16'd20, 1'b0},
        '{12'd12,   16'd12, 16'd40, 1'b0},
        '{12'd8,    16'd11, 16'd40, 1'b1},
        '{12'd2048, 16'd16, 16'd40, 1'b1},
        '{12'd4095, 16'd9,  16'd20, 1'b0},
        '{12'd6,    16'd6,  16'd40, 1'b1},
        '{12'd5,    16'd5,  16'd40, 1'b0}
    };

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic census_res_t predict_census(pixel_word_t w);
        census_res_t                  res;
        int unsigned                  col;
        ct5_pkg::pix_t                a;
        ct5_pkg::pix_t                b;
        ct5_pkg::pix_t                c;
        ct5_pkg::pix_t                d;
        ct5_pkg::pix_t                centre;
        int                           pos;
        logic [ct5_pkg::CENSUS_W-1:0] word;
        if (w.side.frame_start)
        begin
            for (int r = 0; r < ct5_pkg::WIN; r++)
                for (int k = 0; k < ct5_pkg::WIN; k++)
                    win_q[r][k] = '0;
            col_cnt = 0;
            row_cnt = 0;
        end
        col = (col_cnt > ct5_pkg::MAX_WIDTH - 1) ? ct5_pkg::MAX_WIDTH - 1 : col_cnt;
        a = line_store[0][col];
        b = line_store[1][col];
        c = line_store[2][col];
        d = line_store[3][col];
        for (int r = 0; r < ct5_pkg::WIN; r++)
            for (int k = 0; k < ct5_pkg::WIN - 1; k++)
                win_q[r][k] = win_q[r][k+1];
        win_q[0][4] = a;
        win_q[1][4] = b;
        win_q[2][4] = c;
        win_q[3][4] = d;
        win_q[4][4] = w.pixel;
        line_store[0][col] = b;
        line_store[1][col] = c;
        line_store[2][col] = d;
        line_store[3][col] = w.pixel;

        centre = win_q[ct5_pkg::CENTRE][ct5_pkg::CENTRE];
        word = '0;
        pos = 0;
        for (int r = 0; r < ct5_pkg::WIN; r++)
            for (int k = 0; k < ct5_pkg::WIN; k++)
                if (!(r == ct5_pkg::CENTRE && k == ct5_pkg::CENTRE))
                begin
                    word[pos] = (win_q[r][k] >= centre);
                    pos++;
                end
        // The right edge compare is signed, so widths of two or less blank everything.
        if (col < 2 || int'(col) >= int'(lw_model) - 2 || row_cnt < 2)
            word = '0;

        if (w.side.line_end)
        begin
            col_cnt = 0;
            if (row_cnt < 2)
                row_cnt++;
        end
        else if (col < ct5_pkg::MAX_WIDTH - 1)
            col_cnt = col + 1;
        else
            col_cnt = ct5_pkg::MAX_WIDTH - 1;

        res.word = word;
        res.side = w.side;
        return res;
    endfunction

    function automatic int pick_gap(bit idle_on);
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic ct5_pkg::pix_t rand_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            2, 3:    return ct5_pkg::pix_t'($urandom_range(120, 124));
            default: return ct5_pkg::pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(pixel_word_t w, bit known,
                              logic [ct5_pkg::CENSUS_W-1:0] known_word);
        census_res_t res;
        int          gap;
        pixel_bus.valid       <= 1'b1;
        pixel_bus.pixel       <= w.pixel;
        pixel_bus.frame_start <= w.side.frame_start;
        pixel_bus.line_end    <= w.side.line_end;
        pixel_bus.byte_keep   <= w.side.byte_keep;
        pixel_bus.byte_strobe <= w.side.byte_strobe;
        pixel_bus.stream_id   <= w.side.stream_id;
        pixel_bus.stream_dest <= w.side.stream_dest;
        pixel_offered = 1'b1;
        do
            @(posedge clk);
        while (!pixel_bus.ready);
        res = predict_census(w);
        if (known)
            res.word = known_word;
        census_expect.push_back(res);
        gap = pick_gap(src_idle);
        if (gap > 0)
        begin
            pixel_bus.valid <= 1'b0;
            pixel_offered = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic stop_offering();
        if (pixel_offered)
        begin
            pixel_bus.valid <= 1'b0;
            pixel_offered = 1'b0;
        end
    endtask

    task automatic gen_frames(int n, int len, bit noisy, bit new_frame);
        pixel_word_t w;
        int          col;
        col = 0;
        for (int i = 0; i < n; i++)
        begin
            w.pixel = rand_pixel();
            w.side.frame_start = (new_frame && (i == 0 || (col == 0 && $urandom_range(0, 7) == 0)))
                                 || (noisy && $urandom_range(0, 99) < 3);
            if (w.side.frame_start)
                col = 0;
            w.side.line_end    = (col == len - 1) || (noisy && $urandom_range(0, 99) < 4);
            w.side.byte_keep   = 3'($urandom);
            w.side.byte_strobe = 3'($urandom);
            w.side.stream_id   = 1'($urandom);
            w.side.stream_dest = 1'($urandom);
            send_pixel(w, 1'b0, '0);
            col = w.side.line_end ? 0 : col + 1;
        end
    endtask

    task automatic set_line_width(logic [ct5_pkg::LW_W-1:0] value);
        stop_offering();
        while (census_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        lw_model = value;
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    task automatic check_census();
        census_res_t exp_r;
        if (census_expect.size() == 0)
        begin
            $error("census word 0x%0h arrived with nothing expected", census_bus.census_word);
            error_count++;
        end
        else
        begin
            exp_r = census_expect.pop_front();
            check_field("census_word", 32'(exp_r.word), 32'(census_bus.census_word));
            check_field("frame_start_out", 32'(exp_r.side.frame_start),
                        32'(census_bus.frame_start_out));
            check_field("line_end_out", 32'(exp_r.side.line_end),
                        32'(census_bus.line_end_out));
            check_field("byte_keep_out", 32'(exp_r.side.byte_keep),
                        32'(census_bus.byte_keep_out));
            check_field("byte_strobe_out", 32'(exp_r.side.byte_strobe),
                        32'(census_bus.byte_strobe_out));
            check_field("stream_id_out", 32'(exp_r.side.stream_id),
                        32'(census_bus.stream_id_out));
            check_field("stream_dest_out", 32'(exp_r.side.stream_dest),
                        32'(census_bus.stream_dest_out));
        end
    endtask

    // Result side: random gaps, stretches without gaps, and one long hold-off.
    initial
    begin
        int  results_seen;
        int  gap_left;
        bit  sink_idle;
        census_bus.ready = 1'b0;
        results_seen = 0;
        gap_left = 0;
        sink_idle = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (census_bus.valid && census_bus.ready)
            begin
                check_census();
                results_seen++;
                if ($urandom_range(0, 63) == 0)
                    sink_idle = !sink_idle;
                if (results_seen == HOLD_OFF_AT)
                    gap_left = HOLD_OFF_LEN;
                else
                    gap_left = pick_gap(sink_idle);
            end
            if (gap_left > 0)
            begin
                census_bus.ready <= 1'b0;
                gap_left--;
            end
            else
                census_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_bus.valid && pixel_bus.ready) || (census_bus.valid && census_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        pixel_word_t w;
        phase_t      ph;
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = '0;
        pixel_bus.valid       = 1'b0;
        pixel_bus.pixel       = '0;
        pixel_bus.frame_start = 1'b0;
        pixel_bus.line_end    = 1'b0;
        pixel_bus.byte_keep   = '0;
        pixel_bus.byte_strobe = '0;
        pixel_bus.stream_id   = 1'b0;
        pixel_bus.stream_dest = 1'b0;
        quiet_cycles          = 0;
        error_count           = 0;
        pixel_offered         = 1'b0;
        src_idle              = 1'b1;
        for (int s = 0; s < ct5_pkg::STORES; s++)
            for (int k = 0; k < ct5_pkg::MAX_WIDTH; k++)
                line_store[s][k] = '0;
        for (int r = 0; r < ct5_pkg::WIN; r++)
            for (int k = 0; k < ct5_pkg::WIN; k++)
                win_q[r][k] = '0;
        col_cnt  = 0;
        row_cnt  = 0;
        lw_model = ct5_pkg::LINE_WIDTH_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
        begin
            w.pixel            = dir_table[i].pix;
            w.side.frame_start = dir_table[i].sof;
            w.side.line_end    = dir_table[i].eol;
            w.side.byte_keep   = dir_table[i].keep;
            w.side.byte_strobe = dir_table[i].strobe;
            w.side.stream_id   = dir_table[i].id;
            w.side.stream_dest = dir_table[i].dest;
            send_pixel(w, dir_table[i].known, dir_table[i].word);
        end
        gen_frames(60, 9, 1'b0, 1'b1);

        foreach (phase_table[p])
        begin
            ph = phase_table[p];
            set_line_width(ph.lw);
            src_idle = ($urandom_range(0, 3) != 0);
            gen_frames(ph.items, ph.len, ph.noisy, 1'b1);
        end

        stop_offering();
        while (census_expect.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
